FILE: rtl/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, constants and tables for the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int NUM_PAGES   = 64;
    localparam int MAX_SLOTS   = 128;
    localparam int NUM_CLASSES = 8;
    localparam int PAGE_W      = 6;
    localparam int SLOT_W      = 7;
    localparam int CLASS_W     = 3;
    localparam int LINK_W      = 7;   // frame index plus a "no page" bit
    localparam int FREE_W      = 8;
    localparam int BYTES_W     = 20;
    localparam int GB_W        = 12;
    localparam int CNT_W       = 32;

    localparam logic [LINK_W-1:0] NO_PAGE = 7'h40;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_TOO_BIG  = 3'd2,
        ST_NO_PAGES = 3'd3,
        ST_BAD_FREE = 3'd4
    } status_t;

    typedef struct packed {
        logic latch;   // capture request
        logic lookup;  // resolve page, issue memory reads
        logic exec;    // update state, register result
    } cmd_t;

    typedef struct packed {
        logic [LINK_W-1:0]  next;
        logic [CLASS_W-1:0] cls;
        logic [FREE_W-1:0]  free;
    } desc_t;

    function automatic logic [GB_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
        class_bytes = GB_W'(16) << c;
    endfunction

    // (4096 - 48) / ((16 << c) + 24), clipped to 1..128
    function automatic logic [FREE_W-1:0] slots_of(input logic [CLASS_W-1:0] c);
        case (c)
            3'd0:    slots_of = 8'd101;
            3'd1:    slots_of = 8'd72;
            3'd2:    slots_of = 8'd46;
            3'd3:    slots_of = 8'd26;
            3'd4:    slots_of = 8'd14;
            3'd5:    slots_of = 8'd7;
            3'd6:    slots_of = 8'd3;
            default: slots_of = 8'd1;
        endcase
    endfunction

    function automatic logic [MAX_SLOTS-1:0] fresh_map(input logic [CLASS_W-1:0] c);
        logic [FREE_W-1:0] n;
        n = slots_of(c);
        for (int i = 0; i < MAX_SLOTS; i++) begin
            fresh_map[i] = (FREE_W'(i) < n);
        end
    endfunction

    function automatic logic [SLOT_W-1:0] lowest_set(input logic [MAX_SLOTS-1:0] m);
        lowest_set = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                lowest_set = SLOT_W'(i);
            end
        end
    endfunction

endpackage

FILE: rtl/scsa_ctrl.sv
// ----------------------------------------------------------------------------
// scsa_ctrl
// Sequencer: idle, look up the page, execute and write back.
// ----------------------------------------------------------------------------
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_LOOK;
            S_LOOK: state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.latch  = (state_reg == S_IDLE) && start;
    assign cmd.lookup = (state_reg == S_LOOK);
    assign cmd.exec   = (state_reg == S_EXEC);

endmodule

FILE: rtl/scsa_dp.sv
// ----------------------------------------------------------------------------
// scsa_dp
// Datapath: class heads, page descriptor and bitmap memories, totals.
// ----------------------------------------------------------------------------
module scsa_dp
    import scsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                action,
    input  logic [15:0]         request_bytes,
    input  logic [PAGE_W-1:0]   free_page,
    input  logic [SLOT_W-1:0]   free_slot,
    output logic                done,
    output logic [2:0]          status,
    output logic [PAGE_W-1:0]   page,
    output logic [SLOT_W-1:0]   slot,
    output logic [CLASS_W-1:0]  size_class,
    output logic [GB_W-1:0]     granted_bytes,
    output logic [BYTES_W-1:0]  current_bytes,
    output logic [BYTES_W-1:0]  peak_bytes,
    output logic [CNT_W-1:0]    alloc_total,
    output logic [CNT_W-1:0]    free_total,
    output logic [CNT_W-1:0]    fail_total
);

    desc_t                desc_mem [NUM_PAGES];
    logic [MAX_SLOTS-1:0] bm_mem   [NUM_PAGES];
    desc_t                desc_rd_reg;
    logic [MAX_SLOTS-1:0] bm_rd_reg;

    logic [LINK_W-1:0]  head_reg [NUM_CLASSES];
    logic [LINK_W-1:0]  frames_reg;
    logic [BYTES_W-1:0] bytes_reg, peak_reg;
    logic [CNT_W-1:0]   nalloc_reg, nfree_reg, nfail_reg;

    // request capture
    logic               act_reg, zero_reg, big_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [PAGE_W-1:0]  fpage_reg;
    logic [SLOT_W-1:0]  fslot_reg;

    // lookup results
    status_t            err_reg;
    logic               fresh_reg;
    logic [PAGE_W-1:0]  p_reg;

    // result registers
    logic               done_reg;
    status_t            st_reg;
    logic [PAGE_W-1:0]  pg_reg;
    logic [SLOT_W-1:0]  sl_reg;
    logic [CLASS_W-1:0] cl_reg;
    logic [GB_W-1:0]    gb_reg;

    logic [CLASS_W-1:0] req_cls;
    logic               req_big;

    always_comb
    begin
        req_cls = '0;
        req_big = 1'b1;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (request_bytes <= 16'(class_bytes(CLASS_W'(c)))) begin
                req_cls = CLASS_W'(c);
                req_big = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch) begin
            act_reg   <= action;
            zero_reg  <= (request_bytes == '0);
            big_reg   <= req_big;
            cls_reg   <= req_cls;
            fpage_reg <= free_page;
            fslot_reg <= free_slot;
        end
    end

    // lookup: pick the page and start the memory reads
    status_t           look_err;
    logic              look_fresh;
    logic [PAGE_W-1:0] look_p;
    logic [LINK_W-1:0] cur_head;

    assign cur_head = head_reg[cls_reg];

    always_comb
    begin
        look_err   = ST_OK;
        look_fresh = 1'b0;
        look_p     = fpage_reg;
        if (!act_reg) begin
            if (zero_reg)
                look_err = ST_ZERO;
            else if (big_reg)
                look_err = ST_TOO_BIG;
            else if (cur_head[LINK_W-1]) begin
                if (frames_reg[LINK_W-1])
                    look_err = ST_NO_PAGES;
                else begin
                    look_fresh = 1'b1;
                    look_p     = frames_reg[PAGE_W-1:0];
                end
            end else
                look_p = cur_head[PAGE_W-1:0];
        end else if ({1'b0, fpage_reg} >= frames_reg)
            look_err = ST_BAD_FREE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup) begin
            err_reg     <= look_err;
            fresh_reg   <= look_fresh;
            p_reg       <= look_p;
            desc_rd_reg <= desc_mem[look_p];
            bm_rd_reg   <= bm_mem[look_p];
        end
    end

    // execute
    desc_t                cur_desc, new_desc;
    logic [MAX_SLOTS-1:0] cur_bm, new_bm;
    logic [CLASS_W-1:0]   ecls;
    logic [SLOT_W-1:0]    a_slot;
    logic [GB_W-1:0]      egb;
    status_t              est;
    logic                 wr_en;
    logic                 head_wr;
    logic [LINK_W-1:0]    head_val;

    always_comb
    begin
        cur_desc = desc_rd_reg;
        cur_bm   = bm_rd_reg;
        if (fresh_reg) begin
            cur_desc.next = NO_PAGE;
            cur_desc.cls  = cls_reg;
            cur_desc.free = slots_of(cls_reg);
            cur_bm        = fresh_map(cls_reg);
        end
        a_slot   = lowest_set(cur_bm);
        ecls     = act_reg ? cur_desc.cls : cls_reg;
        egb      = class_bytes(ecls);
        est      = err_reg;
        new_desc = cur_desc;
        new_bm   = cur_bm;
        wr_en    = 1'b0;
        head_wr  = 1'b0;
        head_val = NO_PAGE;
        if (err_reg == ST_OK) begin
            if (!act_reg) begin
                wr_en            = 1'b1;
                new_bm[a_slot]   = 1'b0;
                new_desc.free    = cur_desc.free - 8'd1;
                if (new_desc.free == '0) begin
                    // page full: drop it from the class list
                    new_desc.next = NO_PAGE;
                    head_wr       = 1'b1;
                    head_val      = cur_desc.next;
                end else if (fresh_reg) begin
                    head_wr  = 1'b1;
                    head_val = {1'b0, p_reg};
                end
            end else if ({1'b0, fslot_reg} >= slots_of(ecls) || cur_bm[fslot_reg]) begin
                est = ST_BAD_FREE;
            end else begin
                wr_en             = 1'b1;
                new_bm[fslot_reg] = 1'b1;
                new_desc.free     = cur_desc.free + 8'd1;
                if (cur_desc.free == '0) begin
                    // full page comes back: push to head
                    new_desc.next = head_reg[ecls];
                    head_wr       = 1'b1;
                    head_val      = {1'b0, p_reg};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en) begin
            desc_mem[p_reg] <= new_desc;
            bm_mem[p_reg]   <= new_bm;
        end
    end

    logic [BYTES_W-1:0] bytes_up;
    assign bytes_up = bytes_reg + BYTES_W'(egb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= NO_PAGE;
            end
            frames_reg <= '0;
            bytes_reg  <= '0;
            peak_reg   <= '0;
            nalloc_reg <= '0;
            nfree_reg  <= '0;
            nfail_reg  <= '0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= cmd.exec;
            if (cmd.exec) begin
                if (head_wr)
                    head_reg[ecls] <= head_val;
                if (err_reg == ST_OK && !act_reg && fresh_reg)
                    frames_reg <= frames_reg + 7'd1;
                if (est == ST_TOO_BIG || est == ST_NO_PAGES)
                    nfail_reg <= nfail_reg + 32'd1;
                if (est == ST_OK && !act_reg) begin
                    nalloc_reg <= nalloc_reg + 32'd1;
                    bytes_reg  <= bytes_up;
                    if (bytes_up > peak_reg)
                        peak_reg <= bytes_up;
                end
                if (est == ST_OK && act_reg) begin
                    nfree_reg <= nfree_reg + 32'd1;
                    bytes_reg <= bytes_reg - BYTES_W'(egb);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec) begin
            st_reg <= est;
            if (est == ST_OK) begin
                pg_reg <= p_reg;
                sl_reg <= act_reg ? fslot_reg : a_slot;
                cl_reg <= ecls;
                gb_reg <= egb;
            end else if (est == ST_NO_PAGES) begin
                pg_reg <= '0;
                sl_reg <= '0;
                cl_reg <= cls_reg;
                gb_reg <= '0;
            end else if (est == ST_BAD_FREE) begin
                pg_reg <= fpage_reg;
                sl_reg <= fslot_reg;
                cl_reg <= '0;
                gb_reg <= '0;
            end else begin
                pg_reg <= '0;
                sl_reg <= '0;
                cl_reg <= '0;
                gb_reg <= '0;
            end
        end
    end

    assign done          = done_reg;
    assign status        = st_reg;
    assign page          = pg_reg;
    assign slot          = sl_reg;
    assign size_class    = cl_reg;
    assign granted_bytes = gb_reg;
    assign current_bytes = bytes_reg;
    assign peak_bytes    = peak_reg;
    assign alloc_total   = nalloc_reg;
    assign free_total    = nfree_reg;
    assign fail_total    = nfail_reg;

endmodule

FILE: rtl/size_class_slab_allocator.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Power-of-two size-class slot allocator over a fixed pool of page frames.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge enters look-up, which picks the page and reads
// the page descriptor and bitmap memories; execute then updates state and
// registers the result and the done strobe. No new request is taken while busy.
// Reset: class lists empty, no frames claimed, all totals zero; no clearing pass.
// Results are presented for one cycle; the receiver cannot stall.
module size_class_slab_allocator
    import scsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [15:0]         request_bytes,
    input  logic [PAGE_W-1:0]   free_page,
    input  logic [SLOT_W-1:0]   free_slot,
    output logic                done,
    output logic [2:0]          status,
    output logic [PAGE_W-1:0]   page,
    output logic [SLOT_W-1:0]   slot,
    output logic [CLASS_W-1:0]  size_class,
    output logic [GB_W-1:0]     granted_bytes,
    output logic [BYTES_W-1:0]  current_bytes,
    output logic [BYTES_W-1:0]  peak_bytes,
    output logic [CNT_W-1:0]    alloc_total,
    output logic [CNT_W-1:0]    free_total,
    output logic [CNT_W-1:0]    fail_total
);

    cmd_t cmd;

    scsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    scsa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .request_bytes (request_bytes),
        .free_page     (free_page),
        .free_slot     (free_slot),
        .done          (done),
        .status        (status),
        .page          (page),
        .slot          (slot),
        .size_class    (size_class),
        .granted_bytes (granted_bytes),
        .current_bytes (current_bytes),
        .peak_bytes    (peak_bytes),
        .alloc_total   (alloc_total),
        .free_total    (free_total),
        .fail_total    (fail_total)
    );

endmodule

FILE: rtl/scsa_checker.sv
// ----------------------------------------------------------------------------
// scsa_checker
// Port-level checks on the allocator's transaction timing and results.
// ----------------------------------------------------------------------------
module scsa_checker
    import scsa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [2:0]        status,
    input logic [GB_W-1:0]   granted_bytes,
    input logic [BYTES_W-1:0] current_bytes,
    input logic [BYTES_W-1:0] peak_bytes
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 !done ##1 done)
        else $error("result strobe not three cycles after accept");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_BAD_FREE)
        else $error("status code out of range");

    a_fail_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> granted_bytes == '0)
        else $error("failed transaction reports granted bytes");

    a_peak_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK && granted_bytes != '0 && $past(peak_bytes) >= current_bytes
        |-> peak_bytes == $past(peak_bytes))
        else $error("peak moved without a new high");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_bytes (granted_bytes),
    .current_bytes (current_bytes),
    .peak_bytes    (peak_bytes)
);
